// ===== rtl/krtp_pkg.sv =====
package krtp_pkg;

	localparam int unsigned CH_W          = 8;
	localparam int unsigned ID_W          = 32;
	localparam int unsigned KEY_HALF_W    = 64;
	localparam int unsigned KEY_BYTES     = 16;
	localparam int unsigned MAX_ID_DIGITS = 10;

	localparam logic [7:0] CH_COLON   = 8'h3A;
	localparam logic [7:0] CH_DASH    = 8'h2D;
	localparam logic [7:0] CH_NEWLINE = 8'h0A;
	localparam logic [7:0] CH_ZERO    = 8'h30;
	localparam logic [7:0] CH_NINE    = 8'h39;
	localparam logic [7:0] CH_UP_A    = 8'h41;
	localparam logic [7:0] CH_UP_F    = 8'h46;
	localparam logic [7:0] CH_LO_A    = 8'h61;
	localparam logic [7:0] CH_LO_F    = 8'h66;

	localparam logic KIND_RECORD = 1'b0;
	localparam logic KIND_STATUS = 1'b1;

	typedef enum logic [6:0] {
		PH_ID_FIRST = 7'b0000001,
		PH_ID       = 7'b0000010,
		PH_HEX_HI   = 7'b0000100,
		PH_HEX_LO   = 7'b0001000,
		PH_DASH     = 7'b0010000,
		PH_AFTER    = 7'b0100000,
		PH_DONE     = 7'b1000000
	} phase_t;

	typedef struct packed {
		logic                  kind;
		logic [ID_W-1:0]       partner_id;
		logic [KEY_HALF_W-1:0] key_high;
		logic [KEY_HALF_W-1:0] key_low;
		logic                  file_ok;
	} result_t;

	function automatic logic is_dec(input logic [7:0] c);
		return (c >= CH_ZERO) && (c <= CH_NINE);
	endfunction

	// bit 4 set: not a hex digit
	function automatic logic [4:0] hex_val(input logic [7:0] c);
		logic [7:0] d;
		d = 8'h10;
		if ((c >= CH_ZERO) && (c <= CH_NINE)) begin
			d = c - CH_ZERO;
		end else if ((c >= CH_UP_A) && (c <= CH_UP_F)) begin
			d = c - CH_UP_A + 8'd10;
		end else if ((c >= CH_LO_A) && (c <= CH_LO_F)) begin
			d = c - CH_LO_A + 8'd10;
		end
		return d[4:0];
	endfunction

endpackage

// ===== rtl/krtp_char_if.sv =====
interface krtp_char_if;
	logic                           valid;
	logic                           ready;
	logic [krtp_pkg::CH_W-1:0]      ch;
	logic                           end_of_file;

	modport source (output valid, output ch, output end_of_file, input ready);
	modport sink   (input valid, input ch, input end_of_file, output ready);
endinterface

// ===== rtl/krtp_rec_if.sv =====
interface krtp_rec_if;
	logic                             valid;
	logic                             ready;
	logic                             kind;
	logic [krtp_pkg::ID_W-1:0]        partner_id;
	logic [krtp_pkg::KEY_HALF_W-1:0]  key_high;
	logic [krtp_pkg::KEY_HALF_W-1:0]  key_low;
	logic                             file_ok;

	modport source (output valid, output kind, output partner_id, output key_high,
		output key_low, output file_ok, input ready);
	modport sink   (input valid, input kind, input partner_id, input key_high,
		input key_low, input file_ok, output ready);
endinterface

// ===== rtl/key_record_text_parser.sv =====
// Key record text parser: one character or end-of-file mark per word.
// A result word is registered in the output register, or in the skid entry while that register waits.
// Throughput: one input word per cycle; the two-entry output (register plus skid)
// lets input flow while one result waits, and input stalls only when both are full.
// Reset (arst_n low, asynchronous): parser back to expecting the first id digit,
// error cleared, output register and skid empty.
module key_record_text_parser (
	input  logic        clk,
	input  logic        arst_n,
	krtp_char_if.sink   chars,
	krtp_rec_if.source  records
);
	import krtp_pkg::*;

	localparam int unsigned KEY_W = 2 * KEY_HALF_W;

	// parser state
	phase_t           phase_q;
	logic [3:0]       digit_cnt_q;
	logic [ID_W-1:0]  id_q;
	logic [KEY_W-1:0] key_q;
	logic [3:0]       byte_idx_q;
	logic [3:0]       hi_nib_q;
	logic             err_q;

	phase_t           phase_nxt;
	logic [3:0]       digit_cnt_nxt;
	logic [ID_W-1:0]  id_nxt;
	logic [KEY_W-1:0] key_nxt;
	logic [KEY_W-1:0] key_shifted;
	logic [3:0]       byte_idx_nxt;
	logic [3:0]       hi_nib_nxt;
	logic             err_nxt;

	logic [4:0]       hv;
	logic [ID_W-1:0]  dec_digit;
	logic [ID_W-1:0]  id_times_ten;

	result_t          res;
	logic             res_valid;

	// output register and skid entry
	result_t          out_q;
	logic             out_vld_q;
	result_t          skid_q;
	logic             skid_vld_q;

	logic             acc;
	logic             push;
	logic             pop;

	// Accept while the skid entry is free: a result can always land somewhere.
	assign chars.ready = !skid_vld_q;
	assign acc         = chars.valid && chars.ready;
	assign push        = acc && res_valid;
	assign pop         = out_vld_q && records.ready;

	assign hv           = hex_val(chars.ch);
	assign dec_digit    = {{(ID_W-CH_W){1'b0}}, chars.ch - CH_ZERO};
	// times ten as two shifts and an add; wraps modulo 2^32
	assign id_times_ten = {id_q[ID_W-4:0], 3'b000} + {id_q[ID_W-2:0], 1'b0};
	// next key byte enters at the bottom, byte 0 ends up in the top bits
	assign key_shifted  = {key_q[KEY_W-9:0], hi_nib_q, hv[3:0]};

	// One parse step per accepted word.
	always_comb begin
		phase_nxt     = phase_q;
		digit_cnt_nxt = digit_cnt_q;
		id_nxt        = id_q;
		key_nxt       = key_q;
		byte_idx_nxt  = byte_idx_q;
		hi_nib_nxt    = hi_nib_q;
		err_nxt       = err_q;
		res_valid     = 1'b0;
		res           = '0;

		if (chars.end_of_file) begin
			// status word, then back to the start state
			res_valid     = 1'b1;
			res.kind      = KIND_STATUS;
			res.file_ok   = !err_q && ((phase_q == PH_ID_FIRST) ||
				(phase_q == PH_AFTER) || (phase_q == PH_DONE));
			phase_nxt     = PH_ID_FIRST;
			digit_cnt_nxt = '0;
			id_nxt        = '0;
			key_nxt       = '0;
			byte_idx_nxt  = '0;
			hi_nib_nxt    = '0;
			err_nxt       = 1'b0;
		end else if (!err_q) begin
			unique case (phase_q)
				PH_ID_FIRST: begin
					if (is_dec(chars.ch)) begin
						id_nxt        = dec_digit;
						digit_cnt_nxt = 4'd1;
						phase_nxt     = PH_ID;
					end else begin
						err_nxt = 1'b1;
					end
				end
				PH_ID: begin
					if (chars.ch == CH_COLON) begin
						byte_idx_nxt = '0;
						key_nxt      = '0;
						phase_nxt    = PH_HEX_HI;
					end else if (is_dec(chars.ch) &&
						(digit_cnt_q < 4'(MAX_ID_DIGITS))) begin
						id_nxt        = id_times_ten + dec_digit;
						digit_cnt_nxt = digit_cnt_q + 4'd1;
					end else begin
						// too many digits or stray character
						err_nxt = 1'b1;
					end
				end
				PH_HEX_HI: begin
					if (!hv[4]) begin
						hi_nib_nxt = hv[3:0];
						phase_nxt  = PH_HEX_LO;
					end else begin
						err_nxt = 1'b1;
					end
				end
				PH_HEX_LO: begin
					if (hv[4]) begin
						err_nxt = 1'b1;
					end else begin
						key_nxt = key_shifted;
						if (byte_idx_q == 4'(KEY_BYTES - 1)) begin
							// last hex digit completes the record
							phase_nxt      = PH_AFTER;
							res_valid      = 1'b1;
							res.kind       = KIND_RECORD;
							res.partner_id = id_q;
							res.key_high   = key_shifted[KEY_W-1:KEY_HALF_W];
							res.key_low    = key_shifted[KEY_HALF_W-1:0];
							res.file_ok    = 1'b0;
						end else begin
							byte_idx_nxt = byte_idx_q + 4'd1;
							phase_nxt    = PH_DASH;
						end
					end
				end
				PH_DASH: begin
					if (chars.ch == CH_DASH) begin
						phase_nxt = PH_HEX_HI;
					end else begin
						err_nxt = 1'b1;
					end
				end
				PH_AFTER: begin
					// anything but newline ends the file cleanly
					phase_nxt = (chars.ch == CH_NEWLINE) ? PH_ID_FIRST : PH_DONE;
				end
				default: begin
					// done: ignore the rest
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_ID_FIRST;
			digit_cnt_q <= '0;
			id_q        <= '0;
			key_q       <= '0;
			byte_idx_q  <= '0;
			hi_nib_q    <= '0;
			err_q       <= 1'b0;
		end else if (acc) begin
			phase_q     <= phase_nxt;
			digit_cnt_q <= digit_cnt_nxt;
			id_q        <= id_nxt;
			key_q       <= key_nxt;
			byte_idx_q  <= byte_idx_nxt;
			hi_nib_q    <= hi_nib_nxt;
			err_q       <= err_nxt;
		end
	end

	// Output register with one skid entry. The skid only fills when a result
	// arrives while the output register holds a word that is not taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q  <= 1'b0;
			skid_vld_q <= 1'b0;
		end else if (pop) begin
			if (skid_vld_q) begin
				skid_vld_q <= 1'b0;
			end else begin
				out_vld_q <= push;
			end
		end else if (push) begin
			if (out_vld_q) begin
				skid_vld_q <= 1'b1;
			end else begin
				out_vld_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			if (skid_vld_q) begin
				out_q <= skid_q;
			end else if (push) begin
				out_q <= res;
			end
		end else if (push) begin
			if (out_vld_q) begin
				skid_q <= res;
			end else begin
				out_q <= res;
			end
		end
	end

	assign records.valid      = out_vld_q;
	assign records.kind       = out_q.kind;
	assign records.partner_id = out_q.partner_id;
	assign records.key_high   = out_q.key_high;
	assign records.key_low    = out_q.key_low;
	assign records.file_ok    = out_q.file_ok;

	// skid never holds a word ahead of an empty output register
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_vld_q |-> out_vld_q)
		else $error("skid entry valid with empty output register");

	// a record word only comes from the low-nibble phase
	a_record_from_hex_lo: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !chars.end_of_file) |-> (phase_q == PH_HEX_LO))
		else $error("record result outside low-nibble phase");

	// end of file restores the start state
	a_eof_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && chars.end_of_file) |=> ((phase_q == PH_ID_FIRST) && !err_q))
		else $error("end of file did not restart parser");

	// a latched error stays until end of file
	a_err_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		(err_q && !(acc && chars.end_of_file)) |=> err_q)
		else $error("error flag dropped before end of file");

endmodule
